// ===== rtl/core/emms_pkg.sv =====
// Shared types, codes and constants of the espresso machine mode sequencer.
package emms_pkg;

    typedef enum logic [3:0] {
        MODE_INIT       = 4'd0,
        MODE_PREHEAT    = 4'd1,
        MODE_READY      = 4'd2,
        MODE_FAULT      = 4'd3,
        MODE_BREWING    = 4'd4,
        MODE_POSTBREW   = 4'd5,
        MODE_SENSORTEST = 4'd6,
        MODE_UPDATE     = 4'd7,
        MODE_SLEEP      = 4'd8,
        MODE_OFF        = 4'd9
    } t_mode;

    typedef enum logic [1:0] {
        HEATER_BREW  = 2'd0,
        HEATER_STEAM = 2'd1,
        HEATER_SLEEP = 2'd2,
        HEATER_OFF   = 2'd3
    } t_heater;

    typedef enum logic [1:0] {
        DISP_NONE = 2'd0,
        DISP_OFF  = 2'd1,
        DISP_DIM  = 2'd2,
        DISP_FULL = 2'd3
    } t_disp;

    // Command codes; the unused code behaves as a plain tick.
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ON   = 2'd1;
    localparam logic [1:0] CMD_OFF  = 2'd2;

    localparam logic FAULT_NONE      = 1'b0;
    localparam logic FAULT_LOW_WATER = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_TEMP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READY_TEMP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_AFTER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH_TMO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TMO     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEAM_MIN    = 3'd6;

    localparam logic signed [15:0] RST_SLEEP_TEMP = 16'sd1520;
    localparam logic signed [15:0] RST_READY_TEMP = 16'sd1440;
    localparam logic [31:0] RST_FINISH_TMO = 32'd30000;
    localparam logic [31:0] RST_IDLE_TMO   = 32'd1800000;
    localparam logic [15:0] RST_DEBOUNCE   = 16'd500;
    localparam logic [31:0] RST_STEAM_MIN  = 32'd10000;

    typedef struct packed {
        logic signed [15:0] sleep_temperature;
        logic signed [15:0] ready_temperature;
        logic               sleep_after_preheat;
        logic [31:0]        brew_finish_timeout;
        logic [31:0]        idle_timeout;
        logic [15:0]        lever_debounce;
        logic [31:0]        steam_min_brew;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [31:0]        now_ms;
        logic               tank_low;
        logic               lever_pulled;
        logic               temp_valid;
        logic signed [15:0] temperature;
    } t_item;

    typedef struct packed {
        t_mode       mode;
        t_mode       seen;
        logic        fault;
        t_heater     heater;
        logic [31:0] idle_start;
        logic [31:0] brew_start;
        logic [31:0] brew_end;
    } t_state;

    typedef struct packed {
        t_mode       mode;
        logic        fault;
        t_heater     heater;
        t_disp       disp;
        logic        failsafe;
        logic        flow_reset;
        logic        freeze;
        logic [31:0] brew_start;
        logic [31:0] brew_end;
    } t_result;

endpackage

// ===== rtl/core/emms_cfg_regs.sv =====
// Configuration register file of the mode sequencer.
module emms_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [emms_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [31:0]                    i_data,
    output emms_pkg::t_cfg                 o_cfg
);

    emms_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sleep_temperature   <= emms_pkg::RST_SLEEP_TEMP;
            r_cfg.ready_temperature   <= emms_pkg::RST_READY_TEMP;
            r_cfg.sleep_after_preheat <= 1'b0;
            r_cfg.brew_finish_timeout <= emms_pkg::RST_FINISH_TMO;
            r_cfg.idle_timeout        <= emms_pkg::RST_IDLE_TMO;
            r_cfg.lever_debounce      <= emms_pkg::RST_DEBOUNCE;
            r_cfg.steam_min_brew      <= emms_pkg::RST_STEAM_MIN;
        end else if (i_wr_en) begin
            unique case (i_index)
                emms_pkg::CFG_SLEEP_TEMP:  r_cfg.sleep_temperature   <= i_data[15:0];
                emms_pkg::CFG_READY_TEMP:  r_cfg.ready_temperature   <= i_data[15:0];
                emms_pkg::CFG_SLEEP_AFTER: r_cfg.sleep_after_preheat <= i_data[0];
                emms_pkg::CFG_FINISH_TMO:  r_cfg.brew_finish_timeout <= i_data;
                emms_pkg::CFG_IDLE_TMO:    r_cfg.idle_timeout        <= i_data;
                emms_pkg::CFG_DEBOUNCE:    r_cfg.lever_debounce      <= i_data[15:0];
                emms_pkg::CFG_STEAM_MIN:   r_cfg.steam_min_brew      <= i_data;
                default: ;  // drop writes past the last register
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/emms_step.sv =====
// Combinational next-state and result logic for one tick of the sequencer.
module emms_step (
    input  emms_pkg::t_cfg    i_cfg,
    input  emms_pkg::t_item   i_item,
    input  emms_pkg::t_state  i_state,
    output emms_pkg::t_state  o_state,
    output emms_pkg::t_result o_result
);

    emms_pkg::t_state s;
    emms_pkg::t_disp  disp;
    logic             fsafe;
    logic             flow;
    logic             freeze;
    logic [31:0]      now;
    logic [31:0]      since_end;
    logic [31:0]      brew_len;

    always_comb begin
        s      = i_state;
        disp   = emms_pkg::DISP_NONE;
        fsafe  = 1'b0;
        flow   = 1'b0;
        freeze = 1'b0;
        now    = i_item.now_ms;

        // power commands
        if (i_item.cmd == emms_pkg::CMD_ON) begin
            if (s.mode == emms_pkg::MODE_OFF || s.mode == emms_pkg::MODE_SLEEP) begin
                s.mode       = emms_pkg::MODE_PREHEAT;
                s.idle_start = now;
            end
        end else if (i_item.cmd == emms_pkg::CMD_OFF) begin
            s.mode = emms_pkg::MODE_OFF;
        end

        // entry actions on a newly seen mode
        if (s.mode != s.seen) begin
            s.seen = s.mode;
            if (s.mode == emms_pkg::MODE_SLEEP) begin
                disp     = emms_pkg::DISP_DIM;
                s.heater = emms_pkg::HEATER_SLEEP;
            end else if (s.mode == emms_pkg::MODE_OFF) begin
                disp     = emms_pkg::DISP_OFF;
                s.heater = emms_pkg::HEATER_OFF;
                fsafe    = 1'b1;
            end else begin
                disp = emms_pkg::DISP_FULL;
                if (s.heater == emms_pkg::HEATER_SLEEP || s.heater == emms_pkg::HEATER_OFF)
                    s.heater = emms_pkg::HEATER_BREW;
            end
        end

        if (s.mode != emms_pkg::MODE_OFF) begin
            if (i_item.tank_low) begin
                s.fault = emms_pkg::FAULT_LOW_WATER;
                s.mode  = emms_pkg::MODE_FAULT;
            end else begin
                if (s.mode == emms_pkg::MODE_PREHEAT && i_item.temp_valid) begin
                    if (i_item.temperature > i_cfg.sleep_temperature
                            && i_cfg.sleep_after_preheat) begin
                        s.mode = emms_pkg::MODE_SLEEP;
                    end else if (i_item.temperature >= i_cfg.ready_temperature) begin
                        s.mode       = emms_pkg::MODE_READY;
                        s.idle_start = now;
                    end
                end
                // low water cleared
                if (s.mode == emms_pkg::MODE_FAULT && s.fault == emms_pkg::FAULT_LOW_WATER) begin
                    s.fault      = emms_pkg::FAULT_NONE;
                    s.mode       = emms_pkg::MODE_READY;
                    s.idle_start = now;
                end
                if (s.mode != emms_pkg::MODE_BREWING && i_item.lever_pulled) begin
                    if (s.mode == emms_pkg::MODE_SLEEP && i_item.temp_valid
                            && i_item.temperature < i_cfg.ready_temperature) begin
                        s.mode       = emms_pkg::MODE_PREHEAT;
                        s.idle_start = now;
                    end else begin
                        s.mode       = emms_pkg::MODE_BREWING;
                        s.idle_start = now;
                        // a pull within the debounce window keeps the running brew timer
                        if (!(s.brew_end != 32'd0
                                && since_end < {16'd0, i_cfg.lever_debounce})) begin
                            s.brew_start = now;
                            s.brew_end   = 32'd0;
                            flow         = 1'b1;
                        end
                    end
                end else if (s.mode == emms_pkg::MODE_BREWING && !i_item.lever_pulled) begin
                    s.mode       = emms_pkg::MODE_READY;
                    s.idle_start = now;
                    freeze       = 1'b1;
                    s.brew_end   = now;
                    if (brew_len > i_cfg.steam_min_brew)
                        s.heater = emms_pkg::HEATER_STEAM;
                end else if (s.mode == emms_pkg::MODE_READY) begin
                    if (s.brew_end != 32'd0 && since_end >= i_cfg.brew_finish_timeout) begin
                        s.brew_end   = 32'd0;
                        s.brew_start = 32'd0;
                        s.heater     = emms_pkg::HEATER_BREW;
                        s.idle_start = now;
                    end
                    if (s.idle_start != 32'd0 && (now - s.idle_start) >= i_cfg.idle_timeout)
                        s.mode = emms_pkg::MODE_SLEEP;
                end
            end
        end
    end

    // brew_end and brew_start are only touched after these points in their arms
    assign since_end  = i_item.now_ms - i_state.brew_end;
    assign brew_len   = i_item.now_ms - i_state.brew_start;

    assign o_state = s;

    always_comb begin
        o_result.mode       = s.mode;
        o_result.fault      = s.fault;
        o_result.heater     = s.heater;
        o_result.disp       = disp;
        o_result.failsafe   = fsafe;
        o_result.flow_reset = flow;
        o_result.freeze     = freeze;
        o_result.brew_start = s.brew_start;
        o_result.brew_end   = s.brew_end;
    end

endmodule

// ===== rtl/core/espresso_machine_mode_sequencer.sv =====
// Espresso machine mode sequencer: input register, one-tick step logic, result register.
// One word in, one word out, at one word per cycle while the output side takes words:
// a tick is taken into the input register, evaluated by a single combinational pass
// against the mode state, and its result lands in the output register once that
// register is free or being emptied. The mode state advances exactly when a word moves
// from the input to the output register. Configuration writes are taken at any time
// (ready is always high) and should be made only while no tick is in flight.
module espresso_machine_mode_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [emms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_cmd,
    input  logic [31:0]                    i_now_ms,
    input  logic                           i_tank_low,
    input  logic                           i_lever_pulled,
    input  logic                           i_temp_valid,
    input  logic signed [15:0]             i_temperature,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [3:0]                     o_mode_out,
    output logic                           o_fault_out,
    output logic [1:0]                     o_heater_out,
    output logic [1:0]                     o_display_out,
    output logic                           o_failsafe_pulse,
    output logic                           o_flow_reset,
    output logic                           o_graphs_freeze,
    output logic [31:0]                    o_brew_start_out,
    output logic [31:0]                    o_brew_end_out
);

    emms_pkg::t_cfg    cfg;
    emms_pkg::t_state  r_state;
    emms_pkg::t_state  n_state;
    emms_pkg::t_item   r_item;
    emms_pkg::t_result n_result;
    emms_pkg::t_result r_result;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              advance;

    assign o_cfg_ready = 1'b1;

    emms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    emms_step u_step (
        .i_cfg    (cfg),
        .i_item   (r_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // move the held word on whenever the result register is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.cmd          <= i_cmd;
            r_item.now_ms       <= i_now_ms;
            r_item.tank_low     <= i_tank_low;
            r_item.lever_pulled <= i_lever_pulled;
            r_item.temp_valid   <= i_temp_valid;
            r_item.temperature  <= i_temperature;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode       <= emms_pkg::MODE_INIT;
            r_state.seen       <= emms_pkg::MODE_INIT;
            r_state.fault      <= emms_pkg::FAULT_NONE;
            r_state.heater     <= emms_pkg::HEATER_BREW;
            r_state.idle_start <= 32'd0;
            r_state.brew_start <= 32'd0;
            r_state.brew_end   <= 32'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mode_out       = r_result.mode;
    assign o_fault_out      = r_result.fault;
    assign o_heater_out     = r_result.heater;
    assign o_display_out    = r_result.disp;
    assign o_failsafe_pulse = r_result.failsafe;
    assign o_flow_reset     = r_result.flow_reset;
    assign o_graphs_freeze  = r_result.freeze;
    assign o_brew_start_out = r_result.brew_start;
    assign o_brew_end_out   = r_result.brew_end;

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("mode state changed without a word moving on");

    a_failsafe_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_failsafe_pulse |->
            o_mode_out == emms_pkg::MODE_OFF && o_heater_out == emms_pkg::HEATER_OFF)
        else $error("failsafe pulse outside off entry");

    a_flow_brewing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_flow_reset |->
            o_mode_out == emms_pkg::MODE_BREWING && o_brew_end_out == 32'd0)
        else $error("flow reset without a fresh brew");

    a_freeze_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_graphs_freeze |->
            o_mode_out == emms_pkg::MODE_READY && !o_flow_reset)
        else $error("graphs freeze outside brew end");

    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_mode_out == r_state.mode && o_brew_end_out == r_state.brew_end)
        else $error("result register out of step with mode state");

endmodule
